@@ rtl/phd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phd_pkg
// Shared sizes, status codes and cell control type for the pairwise Hamming
// distance matrix block.
// ----------------------------------------------------------------------------
package phd_pkg;

    localparam int NUM_SEQUENCES = 16;
    localparam int MAX_LENGTH    = 4096;

    localparam int SEQ_W  = $clog2(NUM_SEQUENCES + 1);
    localparam int JDX_W  = $clog2(NUM_SEQUENCES);
    localparam int POS_W  = $clog2(MAX_LENGTH + 1);
    localparam int ADDR_W = $clog2(NUM_SEQUENCES * MAX_LENGTH);

    localparam int RES_W  = 8;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 4;
    localparam int CNT_W  = 13;
    localparam int STAT_W = 2;

    localparam int S_TDATA_W  = 8;
    localparam int M_FIELDS_W = ROW_W + COL_W + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic [STAT_W-1:0] status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_LEN_MISM = 2'd1;
    localparam status_t STATUS_TOO_LONG = 2'd2;
    localparam status_t STATUS_TOO_MANY = 2'd3;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ rtl/pairwise_hamming_distance_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_hamming_distance_matrix
// Stores aligned sequences and counts per-pair residue mismatches in a ring
// of counter cells; emits the lower-triangle distances at each sequence end.
//
//   channel  dir  tdata                 tuser          tlast
//   s_       in   residue[7:0]          new_alignment  end_of_sequence
//   m_       out  row,column,mismatch   status[1:0]    last_of_row
//
// a residue that is compared is checked against every stored sequence in one
// pass of the counter ring, behind the registered ram read. a sequence end adds
// a status check, which loads an error word if it fails, else one distance
// word per earlier sequence, held while m_tready is low. the residue store is
// not cleared after reset; its entries are used only after being written.
// ----------------------------------------------------------------------------
module pairwise_hamming_distance_matrix
    import phd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // residue
    input  logic                 s_tlast,
    input  logic                 s_tuser,   // new_alignment
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // row_sequence, column_sequence, mismatch_count
    output logic                 m_tlast,
    output logic [STAT_W-1:0]    m_tuser    // status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_FIN  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [SEQ_W-1:0]  seq_count_reg, seq_count_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  ref_len_reg, ref_len_next;
    logic              ovf_reg, ovf_next;
    logic [RES_W-1:0]  res_reg, res_next;
    logic              eos_reg, eos_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [JDX_W-1:0]  step_reg, step_next;
    logic              issuing_reg, issuing_next;
    logic              rd_v_reg, rd_v_next;
    logic [JDX_W-1:0]  rd_j_reg, rd_j_next;
    logic [JDX_W-1:0]  emit_reg, emit_next;

    logic              m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]  m_row_reg, m_row_next;
    logic [COL_W-1:0]  m_col_reg, m_col_next;
    logic [CNT_W-1:0]  m_cnt_reg, m_cnt_next;
    status_t           m_stat_reg, m_stat_next;
    logic              m_last_reg, m_last_next;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [SEQ_W-1:0]  cnt_eff;
    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  ref_eff;
    logic              ovf_eff;
    logic              do_cmp;
    status_t           fin_status;
    logic              emit_last;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [RES_W-1:0]  ram_rdata;

    cell_ctrl_t        cell_ctrl;
    logic              tail_inc;
    logic [POS_W-1:0]  cell_cnt [NUM_SEQUENCES];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign cnt_eff  = s_tuser ? '0 : seq_count_reg;
    assign pos_eff  = s_tuser ? '0 : pos_reg;
    assign ref_eff  = s_tuser ? '0 : ref_len_reg;
    assign ovf_eff  = s_tuser ? 1'b0 : ovf_reg;

    assign ram_waddr = ADDR_W'(cnt_eff * MAX_LENGTH) + ADDR_W'(pos_eff);
    assign tail_inc  = rd_v_reg && (ram_rdata != res_reg)
                       && (SEQ_W'(rd_j_reg) < seq_count_reg);
    assign emit_last = (SEQ_W'(emit_reg) == seq_count_reg - SEQ_W'(1));

    always_comb begin
        if (seq_count_reg >= SEQ_W'(NUM_SEQUENCES)) begin
            fin_status = STATUS_TOO_MANY;
        end else if (ovf_reg) begin
            fin_status = STATUS_TOO_LONG;
        end else if (seq_count_reg != '0 && pos_reg != ref_len_reg) begin
            fin_status = STATUS_LEN_MISM;
        end else begin
            fin_status = STATUS_OK;
        end
    end

    always_comb begin
        state_next     = state_reg;
        seq_count_next = seq_count_reg;
        pos_next       = pos_reg;
        ref_len_next   = ref_len_reg;
        ovf_next       = ovf_reg;
        res_next       = res_reg;
        eos_next       = eos_reg;
        addr_next      = addr_reg;
        step_next      = step_reg;
        issuing_next   = 1'b0;
        rd_v_next      = 1'b0;
        rd_j_next      = rd_j_reg;
        emit_next      = emit_reg;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        m_cnt_next     = m_cnt_reg;
        m_stat_next    = m_stat_reg;
        m_last_next    = m_last_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        do_cmp         = 1'b0;
        cell_ctrl      = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    seq_count_next  = cnt_eff;
                    ref_len_next    = ref_eff;
                    pos_next        = pos_eff;
                    ovf_next        = ovf_eff;
                    res_next        = s_tdata[RES_W-1:0];
                    eos_next        = s_tlast;
                    addr_next       = ADDR_W'(pos_eff);
                    step_next       = '0;
                    cell_ctrl.clear = s_tuser;
                    if (cnt_eff < SEQ_W'(NUM_SEQUENCES)) begin
                        if (pos_eff >= POS_W'(MAX_LENGTH)) begin
                            ovf_next = 1'b1;
                        end else begin
                            ram_we   = 1'b1;
                            pos_next = pos_eff + POS_W'(1);
                            do_cmp   = (cnt_eff != '0) && (pos_eff < ref_eff);
                        end
                    end
                    if (do_cmp) begin
                        issuing_next = 1'b1;
                        state_next   = S_CMP;
                    end else if (s_tlast) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_CMP: begin
                cell_ctrl.shift = rd_v_reg;
                if (issuing_reg) begin
                    rd_v_next    = 1'b1;
                    rd_j_next    = step_reg;
                    addr_next    = addr_reg + ADDR_W'(MAX_LENGTH);
                    step_next    = step_reg + JDX_W'(1);
                    issuing_next = (step_reg != JDX_W'(NUM_SEQUENCES - 1));
                end
                if (rd_v_reg && rd_j_reg == JDX_W'(NUM_SEQUENCES - 1)) begin
                    state_next = eos_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (fin_status != STATUS_OK) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        m_row_next      = ROW_W'(seq_count_reg);
                        m_col_next      = '0;
                        m_cnt_next      = '0;
                        m_stat_next     = fin_status;
                        m_last_next     = 1'b1;
                        pos_next        = '0;
                        ovf_next        = 1'b0;
                        cell_ctrl.clear = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else if (seq_count_reg == '0) begin
                    ref_len_next    = pos_reg;
                    seq_count_next  = SEQ_W'(1);
                    pos_next        = '0;
                    ovf_next        = 1'b0;
                    cell_ctrl.clear = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    emit_next  = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    m_row_next      = ROW_W'(seq_count_reg);
                    m_col_next      = COL_W'(emit_reg);
                    m_cnt_next      = CNT_W'(cell_cnt[0]);
                    m_stat_next     = STATUS_OK;
                    m_last_next     = emit_last;
                    cell_ctrl.shift = 1'b1;
                    emit_next       = emit_reg + JDX_W'(1);
                    if (emit_last) begin
                        seq_count_next  = seq_count_reg + SEQ_W'(1);
                        pos_next        = '0;
                        ovf_next        = 1'b0;
                        cell_ctrl.clear = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            seq_count_reg <= '0;
            pos_reg       <= '0;
            ref_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            issuing_reg   <= 1'b0;
            rd_v_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seq_count_reg <= seq_count_next;
            pos_reg       <= pos_next;
            ref_len_reg   <= ref_len_next;
            ovf_reg       <= ovf_next;
            issuing_reg   <= issuing_next;
            rd_v_reg      <= rd_v_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        eos_reg    <= eos_next;
        addr_reg   <= addr_next;
        step_reg   <= step_next;
        rd_j_reg   <= rd_j_next;
        emit_reg   <= emit_next;
        m_row_reg  <= m_row_next;
        m_col_reg  <= m_col_next;
        m_cnt_reg  <= m_cnt_next;
        m_stat_reg <= m_stat_next;
        m_last_reg <= m_last_next;
    end

    phd_ram #(
        .WIDTH (RES_W),
        .DEPTH (NUM_SEQUENCES * MAX_LENGTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata[RES_W-1:0]),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // counter ring: each cell takes its upper neighbor, the tail takes the head
    for (genvar k = 0; k < NUM_SEQUENCES; k++) begin : g_cell
        if (k == NUM_SEQUENCES - 1) begin : g_tail
            phd_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl),
                .inc     (tail_inc),
                .cnt_in  (cell_cnt[0]),
                .cnt_out (cell_cnt[k])
            );
        end else begin : g_body
            phd_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl),
                .inc     (1'b0),
                .cnt_in  (cell_cnt[k+1]),
                .cnt_out (cell_cnt[k])
            );
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_cnt_reg, m_col_reg, m_row_reg});
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_stat_reg;

endmodule

@@ rtl/phd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module phd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/phd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phd_cell
// One mismatch counter of the rotating counter chain; takes its neighbor's
// count on a shift and adds the incoming mismatch bit.
// ----------------------------------------------------------------------------
module phd_cell
    import phd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  logic             inc,
    input  logic [POS_W-1:0] cnt_in,
    output logic [POS_W-1:0] cnt_out
);

    logic [POS_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            cnt_reg <= '0;
        end else if (ctrl.shift) begin
            cnt_reg <= cnt_in + POS_W'(inc);
        end
    end

    assign cnt_out = cnt_reg;

endmodule

@@ rtl/phd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phd_checker
// Port-level checks on the result stream of the distance matrix block.
// ----------------------------------------------------------------------------
module phd_checker
    import phd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic [STAT_W-1:0]    m_tuser
);

    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CNT_W-1:0] cnt;

    assign row = m_tdata[ROW_W-1:0];
    assign col = m_tdata[ROW_W+COL_W-1:ROW_W];
    assign cnt = m_tdata[M_FIELDS_W-1:ROW_W+COL_W];

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // error words stand alone with zero column and count
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tlast && col == '0 && cnt == '0)
        else $error("malformed error word");

    // distances lie strictly below the diagonal
    a_lower: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_OK |-> col < row)
        else $error("distance outside the lower triangle");

    a_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_OK && m_tlast |-> col + COL_W'(1) == row)
        else $error("row ended before its last column");

endmodule

bind pairwise_hamming_distance_matrix phd_checker u_phd_checker (.*);
